// ----- rtl/opd_pkg.sv -----
// ----------------------------------------------------------------------------
// opd_pkg
// Shared types and constants of the packet deframer.
// ----------------------------------------------------------------------------
package opd_pkg;

	localparam int LENGTH_WIDTH_DEFAULT = 32;
	localparam int COUNT_WIDTH = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_TAG   = 2'd0;
	localparam logic [1:0] KIND_BODY  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]             out_byte;
		logic [1:0]             kind;
		logic                   last_of_packet;
		logic [COUNT_WIDTH-1:0] packet_length;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_TAG       = 3'd0,
		OP_BODY      = 3'd1,
		OP_BODY_LAST = 3'd2,
		OP_EMPTY_END = 3'd3,
		OP_ABORT     = 3'd4,
		OP_BAD_TAG   = 3'd5
	} op_e;

	typedef struct packed {
		op_e        op;
		logic [7:0] data;
	} op_t;

endpackage

// ----- rtl/opd_front.sv -----
// ----------------------------------------------------------------------------
// opd_front
// Parses the byte stream: tags, length octets and body bytes, and issues one
// operation per byte that produces a result.
// ----------------------------------------------------------------------------
module opd_front import opd_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_item_t item,
	output logic     op_valid,
	output op_t      op
);

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_NEWLEN  = 5'b00010,
		PH_NEWLEN2 = 5'b00100,
		PH_MULTI   = 5'b01000,
		PH_BODY    = 5'b10000
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [31:0]             accum_q, accum_d;
	logic [2:0]              left_q, left_d;
	logic                    partial_q, partial_d;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_d;

	logic        start;
	logic [31:0] slen;
	logic        spart;
	logic [7:0]  b;
	logic [31:0] merged;

	assign b = item.data_byte;
	assign merged = {accum_q[23:0], b};

	always_comb begin
		phase_d   = phase_q;
		accum_d   = accum_q;
		left_d    = left_q;
		partial_d = partial_q;
		rem_d     = rem_q;
		op_valid  = 1'b0;
		op        = '{op: OP_TAG, data: 8'd0};
		start     = 1'b0;
		slen      = 32'd0;
		spart     = 1'b0;
		if (take) begin
			if (item.stream_end) begin
				if (phase_q != PH_IDLE) begin
					op_valid  = 1'b1;
					op        = '{op: OP_ABORT, data: 8'd0};
					phase_d   = PH_IDLE;
					accum_d   = 32'd0;
					left_d    = 3'd0;
					partial_d = 1'b0;
				end
			end else begin
				case (phase_q)
					PH_IDLE: begin
						op_valid = 1'b1;
						if (!b[7] || (!b[6] && b[1:0] == 2'd3)) begin
							op = '{op: OP_BAD_TAG, data: 8'd0};
						end else if (b[6]) begin
							op        = '{op: OP_TAG, data: b};
							partial_d = 1'b0;
							accum_d   = 32'd0;
							phase_d   = PH_NEWLEN;
						end else begin
							op        = '{op: OP_TAG, data: {4'b1000, b[5:2]}};
							partial_d = 1'b0;
							accum_d   = 32'd0;
							left_d    = (b[1:0] == 2'd0) ? 3'd1 :
							            (b[1:0] == 2'd1) ? 3'd2 : 3'd4;
							phase_d   = PH_MULTI;
						end
					end
					PH_NEWLEN: begin
						if (b < 8'd192) begin
							start = 1'b1;
							slen  = {24'd0, b};
						end else if (b <= 8'd223) begin
							accum_d = {16'd0, b - 8'd192, 8'd0} + 32'd192;
							phase_d = PH_NEWLEN2;
						end else if (b < 8'd255) begin
							start = 1'b1;
							spart = 1'b1;
							slen  = 32'd1 << b[4:0];
						end else begin
							accum_d = 32'd0;
							left_d  = 3'd4;
							phase_d = PH_MULTI;
						end
					end
					PH_NEWLEN2: begin
						start = 1'b1;
						slen  = accum_q + {24'd0, b};
					end
					PH_MULTI: begin
						accum_d = merged;
						if (left_q != 3'd0) begin
							left_d = left_q - 3'd1;
						end
						if (left_q <= 3'd1) begin
							start = 1'b1;
							slen  = merged;
						end
					end
					PH_BODY: begin
						op_valid = 1'b1;
						if (rem_q != '0) begin
							rem_d = rem_q - LENGTH_WIDTH'(1);
						end
						if (rem_q <= LENGTH_WIDTH'(1)) begin
							if (partial_q) begin
								op      = '{op: OP_BODY, data: b};
								phase_d = PH_NEWLEN;
							end else begin
								op        = '{op: OP_BODY_LAST, data: b};
								phase_d   = PH_IDLE;
								accum_d   = 32'd0;
								left_d    = 3'd0;
								partial_d = 1'b0;
							end
						end else begin
							op = '{op: OP_BODY, data: b};
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
		if (start) begin
			partial_d = spart;
			accum_d   = 32'd0;
			left_d    = 3'd0;
			if (slen == 32'd0) begin
				if (spart) begin
					phase_d = PH_NEWLEN;
				end else begin
					op_valid = 1'b1;
					op       = '{op: OP_EMPTY_END, data: 8'd0};
					phase_d  = PH_IDLE;
				end
			end else begin
				if ((slen >> LENGTH_WIDTH) != 32'd0) begin
					rem_d = '1;
				end else begin
					rem_d = slen[LENGTH_WIDTH-1:0];
				end
				phase_d = PH_BODY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			accum_q   <= 32'd0;
			left_q    <= 3'd0;
			partial_q <= 1'b0;
			rem_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			accum_q   <= accum_d;
			left_q    <= left_d;
			partial_q <= partial_d;
			rem_q     <= rem_d;
		end
	end

endmodule

// ----- rtl/opd_queue.sv -----
// ----------------------------------------------------------------------------
// opd_queue
// Short first-in first-out queue of operations between parser and formatter.
// ----------------------------------------------------------------------------
module opd_queue import opd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_op,
	input  logic rd_en,
	output op_t  rd_op,
	output logic q_full,
	output logic q_empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	op_t         slots_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	assign q_full  = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_op   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ----- rtl/opd_back.sv -----
// ----------------------------------------------------------------------------
// opd_back
// Carries out queued operations: keeps the packet byte count and holds the
// current result item in an output register.
// ----------------------------------------------------------------------------
module opd_back import opd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  op_t       q_op,
	output logic      q_rd,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic                   out_valid_q;
	out_item_t              out_q;
	out_item_t              out_d;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_inc;

	assign q_rd      = !q_empty && (!out_valid_q || pop);
	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_WIDTH'(1);

	always_comb begin
		out_d.out_byte       = 8'd0;
		out_d.kind           = KIND_ERROR;
		out_d.last_of_packet = 1'b1;
		out_d.packet_length  = '0;
		case (q_op.op)
			OP_TAG: begin
				out_d.out_byte       = q_op.data;
				out_d.kind           = KIND_TAG;
				out_d.last_of_packet = 1'b0;
			end
			OP_BODY: begin
				out_d.out_byte       = q_op.data;
				out_d.kind           = KIND_BODY;
				out_d.last_of_packet = 1'b0;
			end
			OP_BODY_LAST: begin
				out_d.out_byte      = q_op.data;
				out_d.kind          = KIND_BODY;
				out_d.packet_length = count_inc;
			end
			OP_EMPTY_END: begin
				out_d.kind          = KIND_EMPTY;
				out_d.packet_length = count_q;
			end
			OP_ABORT: begin
				out_d.packet_length = count_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (q_rd) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_rd) begin
				case (q_op.op)
					OP_TAG: begin
						count_q <= COUNT_WIDTH'(1);
					end
					OP_BODY, OP_BODY_LAST: begin
						count_q <= count_inc;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/openpgp_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// openpgp_packet_deframer
// Splits a byte stream into packets and reports tag, body and end items.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and gives at most one result item
// per byte, so it sustains one byte per cycle as long as results are popped
// at that pace. A parser decodes tags and lengths combinationally, byte by
// byte, and writes each result operation into a four-entry queue; a formatter
// reads the queue, keeps the packet byte count and presents the item in an
// output register; a result thus passes a queue slot, then that register. Full
// rises only when the queue is full, which takes a stalled result side.
module openpgp_packet_deframer import opd_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic take;
	logic op_valid;
	op_t  op;
	logic q_full;
	logic q_empty;
	logic q_rd;
	op_t  q_op;

	assign full = q_full;
	assign take = push && !q_full;

	opd_front #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.item    (item),
		.op_valid(op_valid),
		.op      (op)
	);

	opd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_valid),
		.wr_op  (op),
		.rd_en  (q_rd),
		.rd_op  (q_op),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	opd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_op   (q_op),
		.q_rd   (q_rd),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ----- rtl/opd_checker.sv -----
// ----------------------------------------------------------------------------
// opd_checker
// Port-level checks of the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module opd_checker import opd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input in_item_t  item,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({push, full, pop, empty}) && (!(push && !full) || !$isunknown(item)))
		else $error("Unknown handshake or accepted item");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.kind == KIND_EMPTY || result.kind == KIND_ERROR))
		|-> result.last_of_packet)
		else $error("End or error item without last flag");

	a_length_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last_of_packet) |-> (result.packet_length == '0))
		else $error("Packet length set on an item that is not last");

	a_tag_form: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_TAG)
		|-> (result.out_byte[7] && !result.last_of_packet))
		else $error("Tag item without bit 7 or marked last");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("Waiting result item changed or vanished");

endmodule

bind openpgp_packet_deframer opd_checker u_opd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.item  (item),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
